// ===== hdl/bfv_pkg.sv =====
package bfv_pkg;

    localparam int MAX_BOIDS_DEF = 32;

    localparam int AX_W       = 16;
    localparam int AXES       = 3;
    localparam int IDX_W      = 5;
    localparam int SUM_W      = 23;
    localparam int MEAN_CNT   = 6;
    localparam int TERM_W     = 24;
    localparam int PROD_W     = 41;
    localparam int WSHIFT     = 12;
    localparam int WV_W       = 28;
    localparam int MAG_W      = 56;
    localparam int ROOT_W     = 28;
    localparam int DVD_W      = 44;
    localparam int DIFF_W     = 17;
    localparam int SQ_W       = 34;
    localparam int D2_W       = 36;
    localparam int ACC_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic signed [AX_W-1:0] t_axis;
    typedef t_axis [AXES-1:0] t_vec3;

    typedef struct packed {
        t_axis pos_x;
        t_axis pos_y;
        t_axis pos_z;
        t_axis vel_x;
        t_axis vel_y;
        t_axis vel_z;
        logic  final_boid;
    } t_boid_in;

    typedef struct packed {
        logic [IDX_W-1:0] boid_index;
        t_axis            new_vel_x;
        t_axis            new_vel_y;
        t_axis            new_vel_z;
        logic             last_result;
    } t_vel_out;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHTS   = 3'd0,
        REG_CLAMPS    = 3'd1,
        REG_BOX_LO    = 3'd2,
        REG_BOX_HI    = 3'd3,
        REG_SEP_RANGE = 3'd4,
        REG_PUSH      = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        TERM_COH = 2'd0,
        TERM_SEP = 2'd1,
        TERM_ALI = 2'd2,
        TERM_BND = 2'd3
    } t_term;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_OWN_RD,
        ST_OWN_LAT,
        ST_SCAN,
        ST_WGT,
        ST_MAG,
        ST_CMP,
        ST_SQRT,
        ST_SCL_MUL,
        ST_SCL_GO,
        ST_SCL_WAIT,
        ST_ADD,
        ST_EMIT
    } t_state;

endpackage

// ===== hdl/bfv_if.sv =====
interface bfv_in_if;
    import bfv_pkg::*;
    logic     valid;
    logic     ready;
    t_boid_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bfv_out_if;
    import bfv_pkg::*;
    logic     valid;
    logic     ready;
    t_vel_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bfv_cfg_if;
    import bfv_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bfv_store.sv =====
module bfv_store #(
    parameter int DEPTH = bfv_pkg::MAX_BOIDS_DEF,
    parameter int AW    = 5
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  bfv_pkg::t_vec3 i_wpos,
    input  bfv_pkg::t_vec3 i_wvel,
    input  logic [AW-1:0]  i_raddr,
    output bfv_pkg::t_vec3 o_rpos,
    output bfv_pkg::t_vec3 o_rvel
);
    import bfv_pkg::*;

    t_vec3 r_pos_mem [DEPTH];
    t_vec3 r_vel_mem [DEPTH];
    t_vec3 r_rpos;
    t_vec3 r_rvel;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pos_mem[i_waddr] <= i_wpos;
            r_vel_mem[i_waddr] <= i_wvel;
        end
        r_rpos <= r_pos_mem[i_raddr];
        r_rvel <= r_vel_mem[i_raddr];
    end

    assign o_rpos = r_rpos;
    assign o_rvel = r_rvel;

endmodule

// ===== hdl/bfv_divider.sv =====
module bfv_divider #(
    parameter int DVD_W = bfv_pkg::DVD_W,
    parameter int DVS_W = bfv_pkg::ROOT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] n_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVD_W-1:0] n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        if (w_shift >= {1'b0, r_dvs}) begin
            n_rem = w_diff[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/bfv_isqrt.sv =====
module bfv_isqrt #(
    parameter int ROOT_W = bfv_pkg::ROOT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*ROOT_W-1:0]   i_value,
    output logic                  o_done,
    output logic [ROOT_W-1:0]     o_root
);
    localparam int IN_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [IN_W-1:0]   r_val;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W-1:0] n_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  w_shift;
    logic [REM_W-1:0]  w_trial;

    always_comb begin
        w_shift = {r_rem[REM_W-3:0], r_val[IN_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        if (w_shift >= w_trial) begin
            n_rem  = w_shift - w_trial;
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_shift;
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[IN_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/boids_flock_velocity_update_unit.sv =====
// Loading: one boid record per cycle; the record marked final starts the update.
// Update: six mean divisions, then for each boid a separation scan that reads one stored
// position per cycle, plus a square root and three divides for each term whose magnitude
// is clamped.
// One transaction on the output per boid; records are accepted again once the last is issued.
// Synchronous active-low reset clears the boid count, the sums, the configuration and control.
module boids_flock_velocity_update_unit #(
    parameter int MAX_BOIDS = bfv_pkg::MAX_BOIDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfv_in_if.sink    i_boid,
    bfv_out_if.source o_vel,
    bfv_cfg_if.sink   i_cfg
);
    import bfv_pkg::*;

    localparam int AW = $clog2(MAX_BOIDS);
    localparam int CW = $clog2(MAX_BOIDS + 1);

    t_state r_state;
    t_state n_state;

    logic [CFG_DATA_W-1:0] r_weights;
    logic [CFG_DATA_W-1:0] r_clamps;
    t_vec3                 r_box_lo;
    t_vec3                 r_box_hi;
    logic [AX_W-1:0]       r_range;
    logic [AX_W-1:0]       r_push;

    logic [CW-1:0]           r_count;
    logic signed [SUM_W-1:0] r_sum [MEAN_CNT];
    t_axis                   r_mean [MEAN_CNT];
    logic [2:0]              r_mk;
    logic [1:0]              r_ck;
    t_term                   r_t;
    logic [AW-1:0]           r_i;
    logic [CW-1:0]           r_j;

    t_vec3                    r_own_p;
    logic signed [TERM_W-1:0] r_term [4][AXES];
    logic signed [WV_W-1:0]   r_wv [AXES];
    logic [MAG_W-1:0]         r_mag2;
    logic [DVD_W-1:0]         r_dvd;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc [AXES];
    logic [2*AX_W-1:0]        r_r2;

    logic                     r_a_v;
    logic                     r_a_self;
    logic                     r_b_v;
    logic                     r_c_v;
    logic signed [DIFF_W-1:0] r_d [AXES];
    logic signed [DIFF_W-1:0] r_dc [AXES];
    logic signed [SQ_W-1:0]   r_sq [AXES];

    t_vel_out r_out;
    logic     r_out_valid;

    logic                     w_in_acc;
    logic                     w_in_rdy;
    logic                     w_store_we;
    logic                     w_issue;
    logic [AW-1:0]            w_raddr;
    t_vec3                    w_rpos;
    t_vec3                    w_rvel;
    t_vec3                    w_in_pos;
    t_vec3                    w_in_vel;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [DVD_W-1:0]         w_div_dvd;
    logic [ROOT_W-1:0]        w_div_dvs;
    logic [DVD_W-1:0]         w_quo;
    logic [DVD_W-1:0]         w_quo_sgn;
    logic                     w_sqrt_start;
    logic                     w_sqrt_done;
    logic [ROOT_W-1:0]        w_root;
    logic signed [SUM_W-1:0]  w_sum_sel;
    logic [SUM_W-1:0]         w_sum_mag;
    logic [3:0][AX_W-1:0]     w_wts;
    logic [3:0][AX_W-1:0]     w_clps;
    logic [AX_W-1:0]          w_wt;
    logic [AX_W-1:0]          w_clamp;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [2*WV_W-1:0] w_sq_wv;
    logic [2*AX_W-1:0]        w_c2;
    logic                     w_clamp_hit;
    logic [WV_W-1:0]          w_wv_mag;
    logic [D2_W-1:0]          w_d2;
    logic                     w_last;
    logic                     w_out_free;
    logic                     w_emit;

    function automatic t_axis sat16(input logic signed [ACC_W-1:0] a);
        t_axis res;
        if (a > ACC_W'(32767)) begin
            res = 16'sh7FFF;
        end else if (a < -ACC_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = a[AX_W-1:0];
        end
        return res;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_boid.valid && i_boid.ready;
    assign w_store_we  = w_in_acc && (r_count < CW'(MAX_BOIDS));
    assign w_in_pos    = {i_boid.data.pos_z, i_boid.data.pos_y, i_boid.data.pos_x};
    assign w_in_vel    = {i_boid.data.vel_z, i_boid.data.vel_y, i_boid.data.vel_x};

    assign w_wts       = r_weights;
    assign w_clps      = r_clamps;
    assign w_wt        = w_wts[r_t];
    assign w_clamp     = w_clps[r_t];
    assign w_prod      = r_term[r_t][r_ck] * signed'({1'b0, w_wt});
    assign w_sq_wv     = r_wv[r_ck] * r_wv[r_ck];
    assign w_c2        = w_clamp * w_clamp;
    assign w_clamp_hit = r_mag2 > MAG_W'(w_c2);
    assign w_wv_mag    = r_wv[r_ck][WV_W-1] ? (WV_W'(0) - unsigned'(r_wv[r_ck]))
                                            : unsigned'(r_wv[r_ck]);

    assign w_sum_sel = r_sum[r_mk];
    assign w_sum_mag = w_sum_sel[SUM_W-1] ? (SUM_W'(0) - unsigned'(w_sum_sel))
                                          : unsigned'(w_sum_sel);
    assign w_div_dvd = (r_state == ST_MEAN_GO) ? DVD_W'(w_sum_mag) : r_dvd;
    assign w_div_dvs = (r_state == ST_MEAN_GO) ? ROOT_W'(r_count) : w_root;
    assign w_quo_sgn = r_neg ? (DVD_W'(0) - w_quo) : w_quo;

    assign w_d2 = D2_W'(unsigned'(r_sq[0])) + D2_W'(unsigned'(r_sq[1]))
                + D2_W'(unsigned'(r_sq[2]));

    assign w_last     = (CW'(r_i) + CW'(1)) == r_count;
    assign w_out_free = !r_out_valid || o_vel.ready;
    assign w_emit     = (r_state == ST_EMIT) && w_out_free;

    bfv_store #(
        .DEPTH (MAX_BOIDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wpos  (w_in_pos),
        .i_wvel  (w_in_vel),
        .i_raddr (w_raddr),
        .o_rpos  (w_rpos),
        .o_rvel  (w_rvel)
    );

    bfv_divider #(
        .DVD_W (DVD_W),
        .DVS_W (ROOT_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    bfv_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (r_mag2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_boid.data.final_boid) n_state = ST_MEAN_GO;
            end
            ST_MEAN_GO: n_state = ST_MEAN_WAIT;
            ST_MEAN_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_mk == 3'(MEAN_CNT - 1)) ? ST_OWN_RD : ST_MEAN_GO;
                end
            end
            ST_OWN_RD: n_state = ST_OWN_LAT;
            ST_OWN_LAT: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_j == r_count && !r_a_v && !r_b_v && !r_c_v) n_state = ST_WGT;
            end
            ST_WGT: begin
                if (r_ck == 2'(AXES - 1)) n_state = ST_MAG;
            end
            ST_MAG: begin
                if (r_ck == 2'(AXES - 1)) n_state = ST_CMP;
            end
            ST_CMP: n_state = w_clamp_hit ? ST_SQRT : ST_ADD;
            ST_SQRT: begin
                if (w_sqrt_done) n_state = ST_SCL_MUL;
            end
            ST_SCL_MUL: n_state = ST_SCL_GO;
            ST_SCL_GO: n_state = ST_SCL_WAIT;
            ST_SCL_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_ck == 2'(AXES - 1)) ? ST_ADD : ST_SCL_MUL;
                end
            end
            ST_ADD: n_state = (r_t == TERM_BND) ? ST_EMIT : ST_WGT;
            ST_EMIT: begin
                if (w_out_free) n_state = w_last ? ST_LOAD : ST_OWN_RD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        w_in_rdy     = 1'b0;
        w_div_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_issue      = 1'b0;
        w_raddr      = r_j[AW-1:0];
        case (r_state)
            ST_LOAD:     w_in_rdy = 1'b1;
            ST_MEAN_GO:  w_div_start = 1'b1;
            ST_OWN_RD:   w_raddr = r_i;
            ST_SCAN:     w_issue = (r_j != r_count);
            ST_CMP:      w_sqrt_start = w_clamp_hit;
            ST_SCL_GO:   w_div_start = 1'b1;
            default:     w_in_rdy = 1'b0;
        endcase
    end

    assign i_boid.ready = w_in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights   <= '0;
            r_clamps    <= '0;
            r_box_lo    <= '0;
            r_box_hi    <= '0;
            r_range     <= '0;
            r_push      <= '0;
            r_count     <= '0;
            r_mk        <= '0;
            r_ck        <= '0;
            r_t         <= TERM_COH;
            r_i         <= '0;
            r_j         <= '0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int m = 0; m < MEAN_CNT; m++) r_sum[m] <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    REG_WEIGHTS:   r_weights <= i_cfg.data.wdata;
                    REG_CLAMPS:    r_clamps  <= i_cfg.data.wdata;
                    REG_BOX_LO:    r_box_lo  <= i_cfg.data.wdata[3*AX_W-1:0];
                    REG_BOX_HI:    r_box_hi  <= i_cfg.data.wdata[3*AX_W-1:0];
                    REG_SEP_RANGE: r_range   <= i_cfg.data.wdata[AX_W-1:0];
                    REG_PUSH:      r_push    <= i_cfg.data.wdata[AX_W-1:0];
                    default:       r_push    <= r_push;
                endcase
            end

            if (w_store_we) begin
                r_count <= r_count + CW'(1);
                for (int k = 0; k < AXES; k++) begin
                    r_sum[k]        <= r_sum[k] + SUM_W'(w_in_pos[k]);
                    r_sum[AXES + k] <= r_sum[AXES + k] + SUM_W'(w_in_vel[k]);
                end
            end

            r_a_v <= w_issue;
            r_b_v <= r_a_v && !r_a_self;
            r_c_v <= r_b_v;

            if (w_issue) r_j <= r_j + CW'(1);

            case (r_state)
                ST_LOAD: r_mk <= '0;
                ST_MEAN_WAIT: begin
                    if (w_div_done) r_mk <= r_mk + 3'd1;
                end
                ST_OWN_LAT: begin
                    r_j <= '0;
                    r_t <= TERM_COH;
                end
                ST_WGT, ST_MAG: begin
                    r_ck <= (r_ck == 2'(AXES - 1)) ? 2'd0 : r_ck + 2'd1;
                end
                ST_SCL_WAIT: begin
                    if (w_div_done) r_ck <= (r_ck == 2'(AXES - 1)) ? 2'd0 : r_ck + 2'd1;
                end
                ST_ADD: begin
                    if (r_t != TERM_BND) r_t <= t_term'(r_t + 2'd1);
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        if (w_last) begin
                            r_count <= '0;
                            r_i     <= '0;
                            for (int m = 0; m < MEAN_CNT; m++) r_sum[m] <= '0;
                        end else begin
                            r_i <= r_i + AW'(1);
                        end
                    end
                end
                default: r_mk <= r_mk;
            endcase

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_vel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_self <= (r_j[AW-1:0] == r_i);

        for (int k = 0; k < AXES; k++) begin
            r_d[k]  <= DIFF_W'(w_rpos[k]) - DIFF_W'(r_own_p[k]);
            r_dc[k] <= r_d[k];
            r_sq[k] <= r_d[k] * r_d[k];
        end

        if (r_c_v && (w_d2 < D2_W'(r_r2))) begin
            for (int k = 0; k < AXES; k++) begin
                r_term[TERM_SEP][k] <= r_term[TERM_SEP][k] - TERM_W'(r_dc[k]);
            end
        end

        case (r_state)
            ST_MEAN_GO: r_neg <= w_sum_sel[SUM_W-1];
            ST_MEAN_WAIT: begin
                if (w_div_done) r_mean[r_mk] <= w_quo_sgn[AX_W-1:0];
            end
            ST_OWN_LAT: begin
                r_own_p <= w_rpos;
                r_r2    <= r_range * r_range;
                for (int k = 0; k < AXES; k++) begin
                    r_term[TERM_COH][k] <= TERM_W'(r_mean[k]) - TERM_W'(w_rpos[k]);
                    r_term[TERM_ALI][k] <= TERM_W'(r_mean[AXES + k]) - TERM_W'(w_rvel[k]);
                    r_term[TERM_SEP][k] <= '0;
                    if (w_rpos[k] < r_box_lo[k]) begin
                        r_term[TERM_BND][k] <= signed'(TERM_W'(r_push));
                    end else if (w_rpos[k] > r_box_hi[k]) begin
                        r_term[TERM_BND][k] <= -signed'(TERM_W'(r_push));
                    end else begin
                        r_term[TERM_BND][k] <= '0;
                    end
                    r_acc[k] <= ACC_W'(w_rvel[k]);
                end
            end
            ST_WGT: begin
                r_wv[r_ck] <= WV_W'(w_prod >>> WSHIFT);
                r_mag2     <= '0;
            end
            ST_MAG: r_mag2 <= r_mag2 + unsigned'(w_sq_wv);
            ST_SCL_MUL: begin
                r_neg <= r_wv[r_ck][WV_W-1];
                r_dvd <= w_wv_mag * w_clamp;
            end
            ST_SCL_WAIT: begin
                if (w_div_done) r_wv[r_ck] <= w_quo_sgn[WV_W-1:0];
            end
            ST_ADD: begin
                for (int k = 0; k < AXES; k++) r_acc[k] <= r_acc[k] + ACC_W'(r_wv[k]);
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_out.boid_index  <= IDX_W'(r_i);
                    r_out.new_vel_x   <= sat16(r_acc[0]);
                    r_out.new_vel_y   <= sat16(r_acc[1]);
                    r_out.new_vel_z   <= sat16(r_acc[2]);
                    r_out.last_result <= w_last;
                end
            end
            default: r_neg <= r_neg;
        endcase
    end

    assign o_vel.valid = r_out_valid;
    assign o_vel.data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOIDS))
        else $error("boid count above capacity");

    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WGT |-> !r_a_v && !r_b_v && !r_c_v)
        else $error("separation pipeline busy during weighting");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_MEAN_WAIT || r_state == ST_SCL_WAIT))
        else $error("divider finished outside a wait state");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && w_last |=> r_count == '0 && r_state == ST_LOAD)
        else $error("flock not cleared after last result");
`endif

endmodule
